// ----- rtl/core/wheel_position_pid_core_assert.svh -----
// ----------------------------------------------------------------------------
// Wheel position PID core assertion macros
// Property wrappers clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef WHEEL_POSITION_PID_CORE_ASSERT_SVH
`define WHEEL_POSITION_PID_CORE_ASSERT_SVH

// same-cycle implication
`define WPP_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WPP_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/wpp_pkg.sv -----
// ----------------------------------------------------------------------------
// Wheel position PID package
// Shared widths, register codes, reset values and the microcode program.
// ----------------------------------------------------------------------------
package wpp_pkg;

	localparam int NUM_WHEELS_DEF = 4;
	localparam int COUNT_BITS_DEF = 24;

	localparam int WHEEL_W    = 2;
	localparam int GAIN_W     = 24;
	localparam int SCALE_W    = 10;
	localparam int DUTY_W     = 8;
	localparam int DIR_W      = 2;
	localparam int INTEG_W    = 48;
	localparam int CHUNK_W    = 24;
	localparam int OPND_W     = 2 * CHUNK_W;
	localparam int PROD_W     = GAIN_W + CHUNK_W + 1;
	localparam int ACC_W      = 76;
	localparam int Q_SHIFT    = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int PERMILLE   = 1000;

	localparam logic [GAIN_W-1:0]  KP_RST    = GAIN_W'(262144);
	localparam logic [GAIN_W-1:0]  KI_RST    = GAIN_W'(77);
	localparam logic [GAIN_W-1:0]  KD_RST    = GAIN_W'(57672);
	localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(20);
	localparam logic [SCALE_W-1:0] BAND_RST  = SCALE_W'(30);

	localparam logic [DIR_W-1:0] DIR_STOP = DIR_W'(0);
	localparam logic [DIR_W-1:0] DIR_FWD  = DIR_W'(1);
	localparam logic [DIR_W-1:0] DIR_REV  = DIR_W'(2);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KP,
		REG_KI,
		REG_KD,
		REG_SCALE,
		REG_BAND
	} cfg_reg_t;

	typedef enum logic [2:0] {
		UOP_NOP,
		UOP_LOAD,
		UOP_UPDATE,
		UOP_DERIV,
		UOP_BAND,
		UOP_EMIT
	} uop_t;

	typedef enum logic [1:0] {
		GAIN_KP,
		GAIN_KI,
		GAIN_KD
	} gain_sel_t;

	typedef enum logic [0:0] {
		SEQ_IDLE,
		SEQ_RUN
	} seq_state_t;

	localparam int STEP_W      = 4;
	localparam int UCODE_DEPTH = 11;

	localparam logic [STEP_W-1:0] STEP_ZERO = STEP_W'(0);
	localparam logic [STEP_W-1:0] STEP_EMIT = STEP_W'(10);

	typedef struct packed {
		uop_t              op;
		logic              mul_en;
		gain_sel_t         gain;
		logic              chunk_hi;
		logic              acc_en;
		logic              jmp_bad;
		logic [STEP_W-1:0] target;
		logic              last;
	} ucode_t;

	typedef struct packed {
		logic   accept;
		logic   fire;
		ucode_t uw;
	} seq_ctl_t;

	typedef struct packed {
		logic wheel_bad;
	} dp_stat_t;

	// load, update, derivative, band check, then six gain*chunk products into the accumulator, then emit
	localparam ucode_t PROGRAM [UCODE_DEPTH] = '{
		'{UOP_LOAD,   1'b0, GAIN_KP, 1'b0, 1'b0, 1'b1, STEP_EMIT, 1'b0},
		'{UOP_UPDATE, 1'b0, GAIN_KP, 1'b0, 1'b0, 1'b0, STEP_ZERO, 1'b0},
		'{UOP_DERIV,  1'b0, GAIN_KP, 1'b0, 1'b0, 1'b0, STEP_ZERO, 1'b0},
		'{UOP_BAND,   1'b1, GAIN_KP, 1'b0, 1'b0, 1'b0, STEP_ZERO, 1'b0},
		'{UOP_NOP,    1'b1, GAIN_KP, 1'b1, 1'b1, 1'b0, STEP_ZERO, 1'b0},
		'{UOP_NOP,    1'b1, GAIN_KI, 1'b0, 1'b1, 1'b0, STEP_ZERO, 1'b0},
		'{UOP_NOP,    1'b1, GAIN_KI, 1'b1, 1'b1, 1'b0, STEP_ZERO, 1'b0},
		'{UOP_NOP,    1'b1, GAIN_KD, 1'b0, 1'b1, 1'b0, STEP_ZERO, 1'b0},
		'{UOP_NOP,    1'b1, GAIN_KD, 1'b1, 1'b1, 1'b0, STEP_ZERO, 1'b0},
		'{UOP_NOP,    1'b0, GAIN_KP, 1'b0, 1'b1, 1'b0, STEP_ZERO, 1'b0},
		'{UOP_EMIT,   1'b0, GAIN_KP, 1'b0, 1'b0, 1'b0, STEP_ZERO, 1'b1}
	};

endpackage

// ----- rtl/core/wpp_mul.sv -----
// ----------------------------------------------------------------------------
// Wheel position PID gain multiplier
// Unsigned gain times one signed operand chunk, product registered.
// ----------------------------------------------------------------------------
module wpp_mul import wpp_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     hi,
	input  logic [GAIN_W-1:0]        gain,
	input  logic signed [CHUNK_W:0]  opnd,
	output logic signed [PROD_W-1:0] prod_s1,
	output logic                     hi_s1
);

	localparam int FULL_W = GAIN_W + CHUNK_W + 2;

	logic signed [FULL_W-1:0] prod_full;

	assign prod_full = FULL_W'($signed({1'b0, gain})) * FULL_W'(opnd);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod_full[PROD_W-1:0];
			hi_s1   <= hi;
		end
	end

endmodule

// ----- rtl/core/wpp_dp.sv -----
// ----------------------------------------------------------------------------
// Wheel position PID datapath
// Config registers, per-wheel state, error arithmetic, accumulator and result.
// ----------------------------------------------------------------------------
module wpp_dp import wpp_pkg::*; #(
	parameter int NUM_WHEELS = NUM_WHEELS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  seq_ctl_t                     ctl,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	input  logic [WHEEL_W-1:0]           wheel_index,
	input  logic signed [COUNT_BITS-1:0] target_count,
	input  logic signed [COUNT_BITS-1:0] measured_count,
	output dp_stat_t                     stat,
	output logic [WHEEL_W-1:0]           wheel_id,
	output logic [DUTY_W-1:0]            pwm_duty,
	output logic [DIR_W-1:0]             drive_dir,
	output logic                         in_band
);

	localparam int E_W    = COUNT_BITS + 1;
	localparam int DIFF_W = COUNT_BITS + 2;
	localparam int DE_W   = DIFF_W + SCALE_W;
	localparam int DEF_W  = DE_W + 1;
	localparam int BAND_W = COUNT_BITS + SCALE_W + 1;
	localparam int ISUM_W = INTEG_W + 1;
	localparam int IDX_W  = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;
	localparam int MAG_LO = Q_SHIFT;
	localparam int MAG_HI = Q_SHIFT + DUTY_W;

	logic [GAIN_W-1:0]  kp_q, ki_q, kd_q;
	logic [SCALE_W-1:0] scale_q, dband_q;

	logic [WHEEL_W-1:0]           wheel_q;
	logic signed [COUNT_BITS-1:0] tgt_q, meas_q;

	logic signed [INTEG_W-1:0] integ_mem [NUM_WHEELS];
	logic signed [E_W-1:0]     last_mem  [NUM_WHEELS];

	logic signed [E_W-1:0]     e_q, last_q;
	logic signed [INTEG_W-1:0] integ_q;
	logic signed [DIFF_W-1:0]  diff_q;
	logic signed [DE_W-1:0]    de_q;
	logic [E_W-1:0]            eabs_q;
	logic [COUNT_BITS-1:0]     tabs_q;
	logic [BAND_W-1:0]         lhs_q, rhs_q;
	logic signed [ACC_W-1:0]   acc_q;

	logic [WHEEL_W-1:0] wheel_id_q;
	logic [DUTY_W-1:0]  pwm_duty_q;
	logic [DIR_W-1:0]   drive_dir_q;
	logic               in_band_q;

	logic                      wheel_bad;
	logic [IDX_W-1:0]          widx;
	logic signed [ISUM_W-1:0]  integ_sum;
	logic signed [INTEG_W-1:0] integ_sat;
	logic signed [DEF_W-1:0]   de_full;
	logic [GAIN_W-1:0]         mul_gain;
	logic signed [OPND_W-1:0]  opnd_full;
	logic signed [CHUNK_W:0]   mul_opnd;
	logic signed [PROD_W-1:0]  prod_s1;
	logic                      hi_s1;
	logic signed [ACC_W-1:0]   prod_ext, addend;
	logic                      s_neg, mag_hi_nz, band, stop;
	logic [ACC_W-1:0]          s_abs;
	logic [DUTY_W-1:0]         mag_lo;

	assign wheel_bad      = int'(wheel_q) >= NUM_WHEELS;
	assign stat.wheel_bad = wheel_bad;
	assign widx           = IDX_W'(wheel_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q    <= KP_RST;
			ki_q    <= KI_RST;
			kd_q    <= KD_RST;
			scale_q <= SCALE_RST;
			dband_q <= BAND_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KP:    kp_q    <= cfg_data;
				REG_KI:    ki_q    <= cfg_data;
				REG_KD:    kd_q    <= cfg_data;
				REG_SCALE: scale_q <= cfg_data[SCALE_W-1:0];
				REG_BAND:  dband_q <= cfg_data[SCALE_W-1:0];
				default:   ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			wheel_q <= wheel_index;
			tgt_q   <= target_count;
			meas_q  <= measured_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WHEELS; i++) begin
				integ_mem[i] <= '0;
				last_mem[i]  <= '0;
			end
		end else if (ctl.fire && ctl.uw.op == UOP_DERIV && !wheel_bad) begin
			integ_mem[widx] <= integ_q;
			last_mem[widx]  <= e_q;
		end
	end

	always_comb begin
		integ_sum = ISUM_W'(integ_q) + ISUM_W'(e_q);
		if (integ_sum[ISUM_W-1] != integ_sum[ISUM_W-2]) begin
			// clamp to the 48-bit rail on the side of the true sum
			integ_sat = integ_sum[ISUM_W-1] ? {1'b1, {(INTEG_W-1){1'b0}}}
				: {1'b0, {(INTEG_W-1){1'b1}}};
		end else begin
			integ_sat = integ_sum[INTEG_W-1:0];
		end
		de_full = DEF_W'(diff_q) * DEF_W'($signed({1'b0, scale_q}));
	end

	always_comb begin
		unique case (ctl.uw.gain)
			GAIN_KP: begin
				mul_gain  = kp_q;
				opnd_full = OPND_W'(e_q);
			end
			GAIN_KI: begin
				mul_gain  = ki_q;
				opnd_full = integ_q;
			end
			GAIN_KD: begin
				mul_gain  = kd_q;
				opnd_full = OPND_W'(de_q);
			end
			default: begin
				mul_gain  = '0;
				opnd_full = '0;
			end
		endcase
		// low chunk is unsigned, high chunk carries the sign
		mul_opnd = ctl.uw.chunk_hi ? {opnd_full[OPND_W-1], opnd_full[OPND_W-1:CHUNK_W]}
			: {1'b0, opnd_full[CHUNK_W-1:0]};
	end

	wpp_mul u_mul (
		.clk     (clk),
		.en      (ctl.fire && ctl.uw.mul_en),
		.hi      (ctl.uw.chunk_hi),
		.gain    (mul_gain),
		.opnd    (mul_opnd),
		.prod_s1 (prod_s1),
		.hi_s1   (hi_s1)
	);

	always_comb begin
		prod_ext  = ACC_W'(prod_s1);
		addend    = hi_s1 ? (prod_ext <<< CHUNK_W) : prod_ext;
		s_neg     = acc_q[ACC_W-1];
		s_abs     = s_neg ? -acc_q : acc_q;
		mag_hi_nz = |s_abs[ACC_W-1:MAG_HI];
		mag_lo    = s_abs[MAG_HI-1:MAG_LO];
		band      = lhs_q < rhs_q;
		stop      = band || (!mag_hi_nz && mag_lo == '0);
	end

	always_ff @(posedge clk) begin
		if (ctl.fire) begin
			unique case (ctl.uw.op)
				UOP_LOAD: begin
					e_q     <= E_W'(tgt_q) - E_W'(meas_q);
					integ_q <= integ_mem[widx];
					last_q  <= last_mem[widx];
					acc_q   <= '0;
				end
				UOP_UPDATE: begin
					integ_q <= integ_sat;
					diff_q  <= DIFF_W'(e_q) - DIFF_W'(last_q);
					eabs_q  <= e_q[E_W-1] ? -e_q : e_q;
					tabs_q  <= tgt_q[COUNT_BITS-1] ? -tgt_q : tgt_q;
				end
				UOP_DERIV: begin
					de_q <= de_full[DE_W-1:0];
				end
				UOP_BAND: begin
					lhs_q <= BAND_W'(eabs_q) * BAND_W'(PERMILLE);
					rhs_q <= BAND_W'(dband_q) * BAND_W'(tabs_q);
				end
				UOP_EMIT: begin
					wheel_id_q <= wheel_q;
					if (wheel_bad) begin
						pwm_duty_q  <= '0;
						drive_dir_q <= DIR_STOP;
						in_band_q   <= 1'b0;
					end else if (stop) begin
						pwm_duty_q  <= '0;
						drive_dir_q <= DIR_STOP;
						in_band_q   <= band;
					end else begin
						pwm_duty_q  <= mag_hi_nz ? '1 : mag_lo;
						drive_dir_q <= s_neg ? DIR_REV : DIR_FWD;
						in_band_q   <= 1'b0;
					end
				end
				default: ;
			endcase
			if (ctl.uw.acc_en) begin
				acc_q <= acc_q + addend;
			end
		end
	end

	assign wheel_id  = wheel_id_q;
	assign pwm_duty  = pwm_duty_q;
	assign drive_dir = drive_dir_q;
	assign in_band   = in_band_q;

endmodule

// ----- rtl/core/wpp_seq.sv -----
// ----------------------------------------------------------------------------
// Wheel position PID sequencer
// Step counter over the microcode program, with input and output handshake.
// ----------------------------------------------------------------------------
module wpp_seq import wpp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  logic     out_stall,
	output logic     out_valid,
	input  dp_stat_t stat,
	output seq_ctl_t ctl
);

	seq_state_t        state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic              out_valid_q, out_valid_d;
	ucode_t            uw;
	logic              hold, fire, accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SEQ_IDLE;
			step_q      <= STEP_ZERO;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			step_q      <= step_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		uw       = PROGRAM[step_q];
		// hold the emit step while the last word still sits unclaimed
		hold     = (uw.op == UOP_EMIT) && out_valid_q && out_stall;
		state_d  = state_q;
		step_d   = step_q;
		accept   = 1'b0;
		fire     = 1'b0;
		in_stall = 1'b1;
		unique case (state_q)
			SEQ_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					accept  = 1'b1;
					state_d = SEQ_RUN;
					step_d  = STEP_ZERO;
				end
			end
			SEQ_RUN: begin
				fire = !hold;
				if (fire) begin
					if (uw.last) begin
						state_d = SEQ_IDLE;
					end else if (uw.jmp_bad && stat.wheel_bad) begin
						step_d = uw.target;
					end else begin
						step_d = step_q + STEP_W'(1);
					end
				end
			end
			default: state_d = SEQ_IDLE;
		endcase
		out_valid_d = (fire && uw.op == UOP_EMIT) || (out_valid_q && out_stall);
		ctl.accept  = accept;
		ctl.fire    = fire;
		ctl.uw      = uw;
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/core/wheel_position_pid_core.sv -----
// ----------------------------------------------------------------------------
// Wheel position PID core
// Discrete PID position controller stepping one of several wheels per word.
//
//   Channel  Role    Handshake            Payload
//   in       sink    in_valid/in_stall    wheel_index, target_count, measured_count
//   out      source  out_valid/out_stall  wheel_id, pwm_duty, drive_dir, in_band
//   cfg      sink    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// An accepted word runs through the 11 microcode steps, and the next word is
// taken only in the idle state that follows the emit step.
// A wheel index at or beyond NUM_WHEELS jumps from the load step to the emit step.
// The program length is set by the one shared 24x25 multiplier, fed one 24-bit
// operand chunk per step for the three gain terms.
// Reset restores the gain registers and clears integral and last error at once.
// A result waits in the output register; the emit step holds only while the
// previous word is still stalled there. Config writes are always ready.
// ----------------------------------------------------------------------------
`include "wheel_position_pid_core_assert.svh"

module wheel_position_pid_core import wpp_pkg::*; #(
	parameter int NUM_WHEELS = NUM_WHEELS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [WHEEL_W-1:0]           wheel_index,
	input  logic signed [COUNT_BITS-1:0] target_count,
	input  logic signed [COUNT_BITS-1:0] measured_count,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [WHEEL_W-1:0]           wheel_id,
	output logic [DUTY_W-1:0]            pwm_duty,
	output logic [DIR_W-1:0]             drive_dir,
	output logic                         in_band,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data
);

	seq_ctl_t seq_ctl;
	dp_stat_t dp_stat;

	assign cfg_ready = 1'b1;

	wpp_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.stat      (dp_stat),
		.ctl       (seq_ctl)
	);

	wpp_dp #(
		.NUM_WHEELS (NUM_WHEELS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (seq_ctl),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.wheel_index    (wheel_index),
		.target_count   (target_count),
		.measured_count (measured_count),
		.stat           (dp_stat),
		.wheel_id       (wheel_id),
		.pwm_duty       (pwm_duty),
		.drive_dir      (drive_dir),
		.in_band        (in_band)
	);

	`WPP_ASSERT_NXT(a_accept_starts_run, in_valid && !in_stall, in_stall, "accepted word did not start the sequencer")
	`WPP_ASSERT_IMP(a_emit_into_free_slot, seq_ctl.fire && seq_ctl.uw.op == UOP_EMIT, !(out_valid && out_stall), "result emitted over a stalled word")
	`WPP_ASSERT_IMP(a_drive_not_in_band, out_valid && pwm_duty != '0, drive_dir != DIR_STOP && !in_band, "nonzero duty with stop or in band")
	`WPP_ASSERT_IMP(a_fire_only_busy, seq_ctl.fire, in_stall && !seq_ctl.accept, "microcode step fired while idle")

endmodule
